// ===== rtl/ctpc_pkg.sv =====
// Shared types and constants for the CIDR text parser and classifier.
// No dependencies; imported by every module of the block.
package ctpc_pkg;

  localparam int unsigned MAX_TEXT_LEN = 18;
  localparam int unsigned MIN_TEXT_LEN = 8;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [3:0] ERR_NONE   = 4'd0;
  localparam logic [3:0] ERR_LENGTH = 4'd1;
  localparam logic [3:0] ERR_CHAR   = 4'd2;
  localparam logic [3:0] ERR_DOTS   = 4'd3;
  localparam logic [3:0] ERR_DIGITS = 4'd4;
  localparam logic [3:0] ERR_SLASH  = 4'd5;
  localparam logic [3:0] ERR_EMPTY  = 4'd6;
  localparam logic [3:0] ERR_OCTET  = 4'd7;
  localparam logic [3:0] ERR_PREFIX = 4'd8;

  localparam logic [2:0] CLASS_A = 3'd0;
  localparam logic [2:0] CLASS_B = 3'd1;
  localparam logic [2:0] CLASS_C = 3'd2;
  localparam logic [2:0] CLASS_D = 3'd3;
  localparam logic [2:0] CLASS_E = 3'd4;

  localparam logic [2:0] KIND_PUBLIC    = 3'd0;
  localparam logic [2:0] KIND_PRIVATE   = 3'd1;
  localparam logic [2:0] KIND_LOOPBACK  = 3'd2;
  localparam logic [2:0] KIND_MULTICAST = 3'd3;
  localparam logic [2:0] KIND_RESERVED  = 3'd4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic        valid_res;
    logic [3:0]  error_code;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic [2:0]  addr_class;
    logic [2:0]  addr_kind;
    logic [31:0] network_addr;
    logic [31:0] broadcast_addr;
    logic [31:0] first_host;
    logic [31:0] last_host;
    logic [31:0] host_count;
  } out_item_t;

  // parsed text handed from the parser to the classifier
  typedef struct packed {
    logic [3:0]  err;
    logic [31:0] address;
    logic [5:0]  prefix;
  } parse_res_t;

  // keep the lowest nonzero error code
  function automatic logic [3:0] note_err(input logic [3:0] cur, input logic [3:0] code);
    logic [3:0] res;
    res = cur;
    if (cur == ERR_NONE || code < cur) res = code;
    return res;
  endfunction

endpackage

// ===== rtl/cidr_text_parser_classifier.sv =====
// IPv4 CIDR text parser and classifier, one character per item.
// Throughput: one character per cycle unless backpressure stalls it.
// A new text may start right after the last one. The result item is registered in the parse
// register and then in the result register; backpressure stalls both.
// Reset (rst_ni, async low) clears the parse state and both stage valids.
// Depends on ctpc_pkg, ctpc_parser and ctpc_classifier.
module cidr_text_parser_classifier import ctpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic       res_valid;
  logic       res_ready;
  parse_res_t res;

  ctpc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  ctpc_classifier u_classifier (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/ctpc_parser.sv =====
// Per-character parser: field accumulation, counters and error tracking.
// Registers the parsed address, prefix and error code on the last item. Uses ctpc_pkg.
module ctpc_parser import ctpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_item_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output parse_res_t res_o
);

  logic [4:0]      cc_q, cc_d;
  logic [2:0]      run_q, run_d;
  logic [9:0]      fv_q, fv_d;
  logic [2:0]      fi_q, fi_d;
  logic [3:0][7:0] oct_q, oct_d;
  logic [2:0]      dots_q, dots_d;
  logic [1:0]      slash_q, slash_d;
  logic [3:0]      err_q, err_d;
  logic            res_vld_q;
  parse_res_t      res_q, res_d;
  logic            accept;

  assign in_ready_o  = !res_vld_q || res_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  always_comb begin
    logic [7:0]  c;
    logic        close;
    logic [13:0] prod;
    logic [3:0]  fin;
    c       = in_item_i.char_code;
    close   = 1'b0;
    cc_d    = cc_q;
    run_d   = run_q;
    fv_d    = fv_q;
    fi_d    = fi_q;
    oct_d   = oct_q;
    dots_d  = dots_q;
    slash_d = slash_q;
    err_d   = err_q;
    prod    = (14'(fv_q) << 3) + (14'(fv_q) << 1) + 14'(c[3:0]);

    if (cc_q == 5'd31) err_d = note_err(err_d, ERR_LENGTH);
    else cc_d = cc_q + 5'd1;

    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (run_q < 3'd3) begin
        fv_d  = prod[9:0];
        run_d = run_q + 3'd1;
      end else begin
        run_d = 3'd4;
        err_d = note_err(err_d, ERR_DIGITS);
      end
    end else if (c == CH_DOT) begin
      if (dots_q != 3'd7) dots_d = dots_q + 3'd1;
      if (slash_q != 2'd0) err_d = note_err(err_d, ERR_DOTS);
      close = 1'b1;
    end else if (c == CH_SLASH) begin
      if (slash_q != 2'd3) slash_d = slash_q + 2'd1;
      if (dots_q != 3'd3) err_d = note_err(err_d, ERR_SLASH);
      close = 1'b1;
    end else begin
      err_d = note_err(err_d, ERR_CHAR);
    end

    if (close) begin
      if (run_q == 3'd0) begin
        err_d = note_err(err_d, ERR_EMPTY);
      end else if (fi_q < 3'd4) begin
        if (fv_q > 10'd255) err_d = note_err(err_d, ERR_OCTET);
        oct_d[fi_q[1:0]] = fv_q[7:0];
      end
      if (fi_q != 3'd7) fi_d = fi_q + 3'd1;
      fv_d  = '0;
      run_d = '0;
    end

    // final field must be the prefix on a good text; an octet closing here
    // always comes with a lower dot error, so its checks are skipped
    fin = err_d;
    if (run_d == 3'd0) begin
      fin = note_err(fin, ERR_EMPTY);
    end else if (fi_d == 3'd4) begin
      if (fv_d > 10'd32) fin = note_err(fin, ERR_PREFIX);
    end
    if (cc_d < 5'(MIN_TEXT_LEN) || cc_d > 5'(MAX_TEXT_LEN)) fin = note_err(fin, ERR_LENGTH);
    if (dots_d != 3'd3) fin = note_err(fin, ERR_DOTS);
    if (slash_d != 2'd1) fin = note_err(fin, ERR_SLASH);
    if (fi_d != 3'd4) fin = note_err(fin, ERR_DOTS);

    res_d.err     = fin;
    res_d.address = {oct_d[0], oct_d[1], oct_d[2], oct_d[3]};
    res_d.prefix  = fv_d[5:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q    <= '0;
      run_q   <= '0;
      fv_q    <= '0;
      fi_q    <= '0;
      oct_q   <= '0;
      dots_q  <= '0;
      slash_q <= '0;
      err_q   <= ERR_NONE;
    end else if (accept) begin
      if (in_item_i.last_char) begin
        cc_q    <= '0;
        run_q   <= '0;
        fv_q    <= '0;
        fi_q    <= '0;
        oct_q   <= '0;
        dots_q  <= '0;
        slash_q <= '0;
        err_q   <= ERR_NONE;
      end else begin
        cc_q    <= cc_d;
        run_q   <= run_d;
        fv_q    <= fv_d;
        fi_q    <= fi_d;
        oct_q   <= oct_d;
        dots_q  <= dots_d;
        slash_q <= slash_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      res_vld_q <= accept && in_item_i.last_char;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_item_i.last_char) res_q <= res_d;
  end

endmodule

// ===== rtl/ctpc_classifier.sv =====
// Class, kind and subnet arithmetic on a parsed address, into the result register.
// Uses ctpc_pkg.
module ctpc_classifier import ctpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       res_valid_i,
  output logic       res_ready_o,
  input  parse_res_t res_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o
);

  logic      out_vld_q;
  out_item_t out_q, out_d;
  logic      accept;

  assign res_ready_o = !out_vld_q || out_ready_i;
  assign accept      = res_valid_i && res_ready_o;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  always_comb begin
    logic [31:0] a;
    logic [31:0] host_mask;
    logic [31:0] net;
    logic [31:0] bc;
    logic [7:0]  o0;
    logic [7:0]  o1;
    logic [2:0]  cls;
    logic [2:0]  kind;
    a         = res_i.address;
    o0        = a[31:24];
    o1        = a[23:16];
    // prefix 32 shifts everything out, prefix 0 keeps all ones
    host_mask = 32'hFFFF_FFFF >> res_i.prefix;
    net       = a & ~host_mask;
    bc        = a | host_mask;

    if (o0 <= 8'd127)      cls = CLASS_A;
    else if (o0 <= 8'd191) cls = CLASS_B;
    else if (o0 <= 8'd223) cls = CLASS_C;
    else if (o0 <= 8'd239) cls = CLASS_D;
    else                   cls = CLASS_E;

    if (cls == CLASS_D)                      kind = KIND_MULTICAST;
    else if (cls == CLASS_E)                 kind = KIND_RESERVED;
    else if (o0 == 8'd127 || a == 32'd0)     kind = KIND_LOOPBACK;
    else if (o0 == 8'd10 || (o0 == 8'd172 && o1 >= 8'd16 && o1 <= 8'd31) ||
             (o0 == 8'd192 && o1 == 8'd168)) kind = KIND_PRIVATE;
    else                                     kind = KIND_PUBLIC;

    out_d            = '0;
    out_d.error_code = res_i.err;
    if (res_i.err == ERR_NONE) begin
      out_d.valid_res      = 1'b1;
      out_d.address        = a;
      out_d.prefix_len     = res_i.prefix;
      out_d.addr_class     = cls;
      out_d.addr_kind      = kind;
      out_d.network_addr   = net;
      out_d.broadcast_addr = bc;
      if (res_i.prefix >= 6'd31) begin
        out_d.first_host = net;
        out_d.last_host  = bc;
        out_d.host_count = '0;
      end else begin
        out_d.first_host = net + 32'd1;
        out_d.last_host  = bc - 32'd1;
        out_d.host_count = host_mask - 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready_o) begin
      out_vld_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_q <= out_d;
  end

endmodule

// ===== tb/cidr_text_parser_classifier_tb.sv =====
// Self-checking testbench for cidr_text_parser_classifier: streams address texts one
// character per item and predicts each parse and classification result in-bench.
// Depends on ctpc_pkg and the block's RTL.
module cidr_text_parser_classifier_tb;
  import ctpc_pkg::*;

  localparam int unsigned RAND_CHARS = 970;
  localparam int unsigned CALM_TAIL  = 200;
  localparam int unsigned WDOG_LIMIT = 500;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  cidr_text_parser_classifier u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  in_item_t    char_q[$];
  out_item_t   parse_results[$];
  logic [7:0]  text_buf[$];
  int unsigned mismatches = 0;

  // parser state as the block should hold it
  logic [4:0] n_chars;
  logic [2:0] run;
  logic [9:0] acc;
  logic [2:0] fld;
  logic [7:0] octs[4];
  logic [2:0] dots;
  logic [1:0] slashes;
  logic [3:0] err;

  int unsigned firsts[12] = '{0, 10, 127, 172, 192, 128, 191, 223, 224, 239, 240, 255};
  int unsigned seconds[6] = '{15, 16, 31, 32, 168, 0};

  function automatic void clear_parse();
    n_chars = '0;
    run     = '0;
    acc     = '0;
    fld     = '0;
    for (int i = 0; i < 4; i++) octs[i] = '0;
    dots    = '0;
    slashes = '0;
    err     = ERR_NONE;
  endfunction

  function automatic void flag_err(input logic [3:0] code);
    if (err == ERR_NONE || code < err) err = code;
  endfunction

  function automatic void end_field();
    if (run == 0) begin
      flag_err(ERR_EMPTY);
    end else if (fld < 4) begin
      if (acc > 255) flag_err(ERR_OCTET);
      octs[fld[1:0]] = acc[7:0];
    end
    if (fld < 7) fld = fld + 3'd1;
    acc = '0;
    run = '0;
  endfunction

  function automatic void parse_char(input in_item_t it);
    logic [7:0]  c;
    logic [5:0]  pfx;
    logic [31:0] a;
    logic [31:0] mask;
    logic [63:0] hosts;
    out_item_t   r;
    c = it.char_code;
    pfx = '0;
    if (n_chars == 5'd31) flag_err(ERR_LENGTH);
    else n_chars = n_chars + 5'd1;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (run < 3) begin
        acc = 10'(acc * 10 + (c - CH_ZERO));
        run = run + 3'd1;
      end else begin
        run = 3'd4;
        flag_err(ERR_DIGITS);
      end
    end else if (c == CH_DOT) begin
      if (dots < 7) dots = dots + 3'd1;
      if (slashes != 0) flag_err(ERR_DOTS);
      end_field();
    end else if (c == CH_SLASH) begin
      if (slashes < 3) slashes = slashes + 2'd1;
      if (dots != 3) flag_err(ERR_SLASH);
      end_field();
    end else begin
      flag_err(ERR_CHAR);
    end
    if (!it.last_char) return;

    // final field: the prefix on a well-formed text
    if (run == 0) begin
      flag_err(ERR_EMPTY);
    end else if (fld == 4) begin
      if (acc > 32) flag_err(ERR_PREFIX);
      pfx = acc[5:0];
    end else if (fld < 4) begin
      if (acc > 255) flag_err(ERR_OCTET);
      octs[fld[1:0]] = acc[7:0];
    end
    if (n_chars < MIN_TEXT_LEN || n_chars > MAX_TEXT_LEN) flag_err(ERR_LENGTH);
    if (dots != 3) flag_err(ERR_DOTS);
    if (slashes != 1) flag_err(ERR_SLASH);
    if (fld != 4) flag_err(ERR_DOTS);

    r = '0;
    r.error_code = err;
    if (err == ERR_NONE) begin
      a = {octs[0], octs[1], octs[2], octs[3]};
      mask = (pfx == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - pfx));
      r.valid_res = 1'b1;
      r.address = a;
      r.prefix_len = pfx;
      if (octs[0] <= 127)      r.addr_class = CLASS_A;
      else if (octs[0] <= 191) r.addr_class = CLASS_B;
      else if (octs[0] <= 223) r.addr_class = CLASS_C;
      else if (octs[0] <= 239) r.addr_class = CLASS_D;
      else                     r.addr_class = CLASS_E;
      if (r.addr_class == CLASS_D)                r.addr_kind = KIND_MULTICAST;
      else if (r.addr_class == CLASS_E)           r.addr_kind = KIND_RESERVED;
      else if (octs[0] == 127 || a == 0)          r.addr_kind = KIND_LOOPBACK;
      else if (octs[0] == 10 || (octs[0] == 172 && octs[1] >= 16 && octs[1] <= 31) ||
               (octs[0] == 192 && octs[1] == 168)) r.addr_kind = KIND_PRIVATE;
      else                                        r.addr_kind = KIND_PUBLIC;
      r.network_addr = a & mask;
      r.broadcast_addr = a | ~mask;
      if (pfx >= 31) begin
        r.first_host = r.network_addr;
        r.last_host = r.broadcast_addr;
        r.host_count = '0;
      end else begin
        hosts = (64'd1 << (32 - pfx)) - 64'd2;
        r.first_host = r.network_addr + 32'd1;
        r.last_host = r.broadcast_addr - 32'd1;
        r.host_count = hosts[31:0];
      end
    end
    parse_results.push_back(r);
    clear_parse();
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // text building
  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function automatic int unsigned flush_text();
    in_item_t    it;
    int unsigned n;
    n = text_buf.size();
    for (int i = 0; i < n; i++) begin
      it.char_code = text_buf[i];
      it.last_char = (i == n - 1);
      char_q.push_back(it);
    end
    text_buf.delete();
    return n;
  endfunction

  function automatic void send_text(input string s);
    add_str(s);
    void'(flush_text());
  endfunction

  function automatic string octet_text(input int unsigned v);
    if ($urandom_range(0, 7) == 0) return $sformatf("%03d", v);
    return $sformatf("%0d", v);
  endfunction

  function automatic int unsigned edge_octet();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic void build_cidr();
    int unsigned o[4];
    int unsigned pfx;
    o[0] = $urandom_range(0, 1) ? firsts[$urandom_range(0, 11)] : $urandom_range(0, 255);
    o[1] = ($urandom_range(0, 2) == 0) ? seconds[$urandom_range(0, 5)] : edge_octet();
    o[2] = edge_octet();
    o[3] = edge_octet();
    if ($urandom_range(0, 19) == 0) begin
      o[0] = 0; o[1] = 0; o[2] = 0; o[3] = 0;
    end
    case ($urandom_range(0, 9))
      0: pfx = $urandom_range(33, 999);
      1: pfx = $urandom_range(0, 1) ? 32 : 0;
      default: pfx = $urandom_range(0, 32);
    endcase
    add_str($sformatf("%s.%s.%s.%s/%s", octet_text(o[0]), octet_text(o[1]),
                      octet_text(o[2]), octet_text(o[3]), octet_text(pfx)));
  endfunction

  function automatic logic [7:0] noise_char();
    string punct;
    punct = "0123456789./";
    if ($urandom_range(0, 1)) return punct[$urandom_range(0, 11)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void build_random_text();
    int unsigned k;
    int unsigned n;
    case ($urandom_range(0, 9))
      7: begin
        // built CIDR text with one defect
        build_cidr();
        k = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 3))
          0: text_buf[k] = 8'($urandom_range(0, 255));
          1: text_buf.delete(k);
          2: text_buf.insert(k, noise_char());
          default: while (text_buf.size() > k + 1) void'(text_buf.pop_back());
        endcase
      end
      8: begin
        n = $urandom_range(1, 40);
        repeat (n) text_buf.push_back(noise_char());
      end
      9: begin
        n = $urandom_range(19, 40);
        repeat (n) text_buf.push_back(($urandom_range(0, 3) == 0) ? CH_DOT :
                                      8'(CH_ZERO + $urandom_range(0, 9)));
      end
      default: build_cidr();
    endcase
  endfunction

  // driver: new item on the falling edge once the previous one is taken and any random gap is over
  logic        char_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || char_taken)) begin
      if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (char_q.size() != 0) begin
        in_item_i <= char_q.pop_front();
        in_valid_i <= 1'b1;
        if (char_q.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
          send_gap <= $urandom_range(1, 15);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_stall != 0) begin
        out_ready_i <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else begin
        out_ready_i <= 1'b1;
        if (char_q.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
          recv_stall <= $urandom_range(1, 15);
      end
    end
  end

  // monitor, predictor and watchdog on the rising edge
  out_item_t   want;
  int unsigned quiet = 0;

  always @(posedge clk_i) begin
    char_taken <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) parse_char(in_item_i);
    if (out_valid_o && out_ready_i) begin
      if (parse_results.size() == 0) begin
        $display("%0t: result with none expected, error_code %0d", $time,
                 out_item_o.error_code);
        mismatches++;
      end else begin
        want = parse_results.pop_front();
        check_field("valid_res", 32'(want.valid_res), 32'(out_item_o.valid_res));
        check_field("error_code", 32'(want.error_code), 32'(out_item_o.error_code));
        check_field("address", want.address, out_item_o.address);
        check_field("prefix_len", 32'(want.prefix_len), 32'(out_item_o.prefix_len));
        check_field("addr_class", 32'(want.addr_class), 32'(out_item_o.addr_class));
        check_field("addr_kind", 32'(want.addr_kind), 32'(out_item_o.addr_kind));
        check_field("network_addr", want.network_addr, out_item_o.network_addr);
        check_field("broadcast_addr", want.broadcast_addr, out_item_o.broadcast_addr);
        check_field("first_host", want.first_host, out_item_o.first_host);
        check_field("last_host", want.last_host, out_item_o.last_host);
        check_field("host_count", want.host_count, out_item_o.host_count);
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet <= 0;
    end else if (quiet >= WDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int unsigned sent;
    clear_parse();

    send_text("192.168.1.1/24");
    send_text("0.0.0.0/0");
    send_text("255.255.255.255/32");
    send_text("10.0.0.1/8");
    send_text("127.0.0.1/31");
    send_text("172.16.5.4/12");
    send_text("172.31.0.0/16");
    send_text("172.32.0.0/16");
    send_text("224.0.0.1/4");
    send_text("240.1.2.3/30");
    send_text("1.2.3.4/5");
    send_text("1.2.3/4");             // too short
    send_text("1.2.3.4/");            // trailing slash
    send_text("1.2.3.4.");            // trailing dot
    send_text("1..2.3/24");
    send_text("1234.1.1.1/8");        // fourth digit
    send_text("1.2.3.4/5.6");         // dot after slash
    send_text("1.2/3.4.5");           // slash early
    send_text("256.1.1.1/8");
    send_text("1.1.1.1/33");
    send_text("1.2.3.4//5");
    send_text("5");
    send_text("12.34.56.78.90.12.34.56.78/9");  // over long
    add_str("1.2.3.");
    text_buf.push_back(8'hFF);
    add_str("/8");
    void'(flush_text());
    text_buf.push_back(8'h00);
    add_str("1.2.3.4/8");
    void'(flush_text());

    sent = 0;
    while (sent < RAND_CHARS) begin
      build_random_text();
      sent += flush_text();
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (char_q.size() != 0 || in_valid_i || parse_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
